### src/pwm_pkg.sv
package pwm_pkg;

   // field widths of the stream words
   localparam int BASE_BITS      = 3;
   localparam int COLUMN_BITS    = 5;
   localparam int IN_WEIGHT_BITS = 16;
   localparam int SEQ_BITS       = 8;
   localparam int START_BITS     = 16;
   localparam int SCORE_BITS     = 21;
   localparam int LEN_CFG_BITS   = 6;
   localparam int NUM_BASES      = 4;

   localparam int REQ_DATA_BITS = 24;
   localparam int REQ_USER_BITS = 2;
   localparam int RSP_DATA_BITS = 48;
   localparam int CSR_DATA_BITS = 21;
   localparam int CSR_INDEX_BITS = 1;

   // symbol used for anything that is not a, c, g or t
   localparam logic [BASE_BITS-1:0] SYM_OTHER = 3'd4;

   localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = 21'sd1048575;
   localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = -21'sd1048576;

   // reset values of the control registers (-1.78 in q8.12)
   localparam int LEN_RESET = 16;
   localparam logic signed [SCORE_BITS-1:0] THRESH_RESET = -21'sd7291;

   typedef enum logic [REQ_USER_BITS-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SCAN   = 2'd1,
      CMD_NEWSEQ = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MOTIF_LENGTH    = 1'd0,
      CSR_SCORE_THRESHOLD = 1'd1
   } csr_reg_type;

   // control broadcast to every column cell
   typedef struct packed {
      logic                   shift;
      logic                   clear;
      logic                   load;
      logic [COLUMN_BITS-1:0] column;
      logic [1:0]             base;
   } cell_ctrl_type;

   // side information travelling with a window through the adder tree
   typedef struct packed {
      logic                  valid;
      logic [SEQ_BITS-1:0]   seq;
      logic [START_BITS-1:0] start;
   } tag_type;

   typedef struct packed {
      logic signed [SCORE_BITS-1:0] score;
      logic [START_BITS-1:0]        start;
      logic [SEQ_BITS-1:0]          seq;
   } rsp_word_type;

endpackage

### src/pwm_cell.sv
module pwm_cell #(
   parameter int COL         = 0,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pwm_pkg::cell_ctrl_type            ctrl,
   input  logic signed [WEIGHT_BITS-1:0]     load_weight,
   input  logic [pwm_pkg::BASE_BITS-1:0]     sym_in,
   output logic [pwm_pkg::BASE_BITS-1:0]     sym_out,
   input  logic [pwm_pkg::BASE_BITS-1:0]     aligned_sym,
   output logic signed [WEIGHT_BITS-1:0]     contrib
);
   import pwm_pkg::*;

   logic [BASE_BITS-1:0]          sym_ff;
   logic signed [WEIGHT_BITS-1:0] weight_ff [NUM_BASES];
   logic signed [WEIGHT_BITS-1:0] contrib_ff;
   logic                          col_hit;

   // only columns reachable by the load field can be written
   assign col_hit = (COL < (1 << COLUMN_BITS)) && (ctrl.column == COLUMN_BITS'(COL));

   // history tap: one symbol handed on to the next cell per scanned base
   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= SYM_OTHER;
      end else if (ctrl.clear) begin
         sym_ff <= SYM_OTHER;
      end else if (ctrl.shift) begin
         sym_ff <= sym_in;
      end
   end

   // weights of this column, one per base
   always_ff @(posedge clock) begin
      if (ctrl.load && col_hit) begin
         weight_ff[ctrl.base] <= load_weight;
      end
   end

   // contribution of the symbol aligned with this column, other adds zero
   always_ff @(posedge clock) begin
      if (aligned_sym[BASE_BITS-1]) begin
         contrib_ff <= '0;
      end else begin
         contrib_ff <= weight_ff[aligned_sym[1:0]];
      end
   end

   assign sym_out = sym_ff;
   assign contrib = contrib_ff;

endmodule

### src/pwm_sum_tree.sv
module pwm_sum_tree #(
   parameter int N        = 32,
   parameter int IN_BITS  = 16,
   parameter int SUM_BITS = 21,
   parameter int TAG_BITS = 25
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [IN_BITS-1:0]  leaf [N],
   input  logic [TAG_BITS-1:0]        tag_in,
   output logic signed [SUM_BITS-1:0] sum,
   output logic [TAG_BITS-1:0]        tag_out
);
   import pwm_pkg::*;

   localparam int LOG = $clog2(N);
   localparam int P   = 1 << LOG;

   if (LOG == 0) begin : g_single
      assign sum     = SUM_BITS'(leaf[0]);
      assign tag_out = tag_in;
   end else begin : g_tree
      // heap layout: node 1 is the root, children of i are 2i and 2i+1
      logic signed [SUM_BITS-1:0] node_ff [1:P-1];
      logic [TAG_BITS-1:0]        tag_ff  [1:LOG];

      for (genvar i = 1; i < P; i++) begin : g_node
         localparam int LI = 2 * i - P;
         logic signed [SUM_BITS-1:0] lhs;
         logic signed [SUM_BITS-1:0] rhs;

         if (2 * i >= P) begin : g_bottom
            if (LI < N) begin : g_lhs
               assign lhs = SUM_BITS'(leaf[LI]);
            end else begin : g_lhs_pad
               assign lhs = '0;
            end
            if (LI + 1 < N) begin : g_rhs
               assign rhs = SUM_BITS'(leaf[LI + 1]);
            end else begin : g_rhs_pad
               assign rhs = '0;
            end
         end else begin : g_inner
            assign lhs = node_ff[2 * i];
            assign rhs = node_ff[2 * i + 1];
         end

         // one registered add per node
         always_ff @(posedge clock) begin
            node_ff[i] <= lhs + rhs;
         end
      end

      // tag follows the partial sums level by level
      always_ff @(posedge clock) begin
         if (reset) begin
            for (int l = 1; l <= LOG; l++) begin
               tag_ff[l] <= '0;
            end
         end else begin
            tag_ff[1] <= tag_in;
            for (int l = 2; l <= LOG; l++) begin
               tag_ff[l] <= tag_ff[l - 1];
            end
         end
      end

      assign sum     = node_ff[1];
      assign tag_out = tag_ff[LOG];
   end

endmodule

### src/pwm_fifo.sv
module pwm_fifo #(
   parameter int WIDTH = 45,
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             not_empty
);
   import pwm_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata     = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);

endmodule

### src/pwm_motif_scan.sv
// channel   dir  handshake          payload
// req_      in   tvalid / tready    tuser: cmd; tdata: base, column, weight
// rsp_      out  tvalid / tready    tdata: sequence_index, start_position, score
// csr_      in   wr_en              index: register; wdata: value
//
// one word per cycle on the request side while req_tready is high; a hit
// passes the history, contribution and adder tree registers into the result queue
// the queue of 2^clog2(clog2(MAX_MOTIF_LEN) + 5) results holds back req_tready
// only once full-window scans in flight and queued results fill it
// synchronous reset clears window, position and sequence counter and sets the
// registers to their reset values; weights are undefined until loaded
module pwm_motif_scan #(
   parameter int MAX_MOTIF_LEN = 32,
   parameter int WEIGHT_BITS   = 16,
   parameter int POSITION_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // base [2:0], column [7:3], weight [23:8]
   input  logic [pwm_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // cmd [1:0]
   input  logic [pwm_pkg::REQ_USER_BITS-1:0]    req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // sequence_index [7:0], start_position [23:8], score [44:24], zero [47:45]
   output logic [pwm_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   input  logic                                 csr_wr_en,
   input  logic [pwm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pwm_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import pwm_pkg::*;

   localparam int LOG         = $clog2(MAX_MOTIF_LEN);
   localparam int SHB         = (LOG > 0) ? LOG : 1;
   localparam int LENB        = $clog2(MAX_MOTIF_LEN + 1);
   localparam int SUM_BITS    = WEIGHT_BITS + LOG;
   localparam int EXT_BITS    = SUM_BITS + SCORE_BITS;
   localparam int LATENCY     = LOG + 1;
   localparam int FIFO_DEPTH  = 1 << $clog2(LATENCY + 4);
   localparam int CREDIT_BITS = $clog2(FIFO_DEPTH + 1);
   localparam int PW          = ((POSITION_BITS > START_BITS) ? POSITION_BITS : START_BITS) + 1;
   localparam int WX          = ((WEIGHT_BITS > IN_WEIGHT_BITS) ? WEIGHT_BITS : IN_WEIGHT_BITS) + 1;
   localparam int TAG_BITS    = $bits(tag_type);
   localparam int LEN_RST     = (LEN_RESET > MAX_MOTIF_LEN) ? MAX_MOTIF_LEN : LEN_RESET;
   localparam logic signed [WX-1:0] WMAX = (WX'(1) <<< (WEIGHT_BITS - 1)) - WX'(1);
   localparam logic signed [WX-1:0] WMIN = -WMAX - WX'(1);

   // request word fields
   cmd_type                          req_cmd;
   logic [BASE_BITS-1:0]             req_base;
   logic [COLUMN_BITS-1:0]           req_column;
   logic signed [IN_WEIGHT_BITS-1:0] req_weight;

   logic accept;
   logic is_load;
   logic is_scan;
   logic is_newseq;

   // registers
   logic [LENB-1:0]                len_ff, len_in;
   logic signed [SCORE_BITS-1:0]   thresh_ff;
   logic [POSITION_BITS-1:0]       seen_ff, seen_in, seen_scan;
   logic [SEQ_BITS-1:0]            seq_ff, seq_in;
   tag_type                        s0_tag_ff, s0_tag_in;
   tag_type                        s1_tag_ff;
   logic [CREDIT_BITS-1:0]         credit_ff, credit_in;

   logic                           full;
   logic [START_BITS-1:0]          start;
   logic [SHB-1:0]                 sh;
   logic signed [WX-1:0]           weight_wide;
   logic signed [WEIGHT_BITS-1:0]  weight_sat;
   cell_ctrl_type                  ctrl;

   logic [BASE_BITS-1:0]           hist    [MAX_MOTIF_LEN];
   logic [BASE_BITS-1:0]           aligned [MAX_MOTIF_LEN];
   logic signed [WEIGHT_BITS-1:0]  contrib [MAX_MOTIF_LEN];

   logic signed [SUM_BITS-1:0]     root;
   logic [TAG_BITS-1:0]            root_tag_bits;
   tag_type                        root_tag;
   logic signed [EXT_BITS-1:0]     root_ext;
   logic signed [SCORE_BITS-1:0]   score_sat;
   logic                           hit;
   logic                           drop;
   logic                           reserve;
   logic                           pop;
   rsp_word_type                   push_word;
   logic [$bits(rsp_word_type)-1:0] fifo_rdata;
   rsp_word_type                   out_word;

   assign req_cmd    = cmd_type'(req_tuser);
   assign req_base   = req_tdata[2:0];
   assign req_column = req_tdata[7:3];
   assign req_weight = $signed(req_tdata[23:8]);

   assign accept = req_tvalid && req_tready;

   // command decode
   always_comb begin
      is_load   = 1'b0;
      is_scan   = 1'b0;
      is_newseq = 1'b0;
      case (req_cmd)
         CMD_LOAD:   is_load   = 1'b1;
         CMD_SCAN:   is_scan   = 1'b1;
         CMD_NEWSEQ: is_newseq = 1'b1;
         default:    ;
      endcase
   end

   // motif length clamped into 1..MAX_MOTIF_LEN when written
   always_comb begin
      if (csr_wdata[LEN_CFG_BITS-1:0] == '0) begin
         len_in = LENB'(1);
      end else if (int'(csr_wdata[LEN_CFG_BITS-1:0]) > MAX_MOTIF_LEN) begin
         len_in = LENB'(MAX_MOTIF_LEN);
      end else begin
         len_in = LENB'(csr_wdata[LEN_CFG_BITS-1:0]);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= LENB'(LEN_RST);
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            CSR_MOTIF_LENGTH:    len_ff    <= len_in;
            CSR_SCORE_THRESHOLD: thresh_ff <= $signed(csr_wdata[SCORE_BITS-1:0]);
            default:             ;
         endcase
      end
   end

   // position within the sequence, saturating, and window start
   always_comb begin
      seen_scan = (seen_ff == '1) ? seen_ff : seen_ff + 1'b1;
      full      = (PW'(seen_scan) >= PW'(len_ff));
      start     = START_BITS'(PW'(seen_scan) - PW'(len_ff) + PW'(1));
      seen_in   = seen_ff;
      seq_in    = seq_ff;
      if (accept && is_newseq) begin
         seen_in = '0;
         seq_in  = seq_ff + 1'b1;
      end else if (accept && is_scan) begin
         seen_in = seen_scan;
      end
      s0_tag_in.valid = accept && is_scan && full;
      s0_tag_in.seq   = seq_ff;
      s0_tag_in.start = start;
   end

   assign reserve = s0_tag_in.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= '0;
         seq_ff    <= '0;
         s0_tag_ff <= '0;
         s1_tag_ff <= '0;
      end else begin
         seen_ff   <= seen_in;
         seq_ff    <= seq_in;
         s0_tag_ff <= s0_tag_in;
         s1_tag_ff <= s0_tag_ff;
      end
   end

   // loaded weight saturated to the table width
   always_comb begin
      weight_wide = WX'(req_weight);
      if (weight_wide > WMAX) begin
         weight_sat = WEIGHT_BITS'(WMAX);
      end else if (weight_wide < WMIN) begin
         weight_sat = WEIGHT_BITS'(WMIN);
      end else begin
         weight_sat = WEIGHT_BITS'(weight_wide);
      end
   end

   always_comb begin
      ctrl.shift  = accept && is_scan;
      ctrl.clear  = accept && is_newseq;
      ctrl.load   = accept && is_load && !req_base[BASE_BITS-1];
      ctrl.column = req_column;
      ctrl.base   = req_base[1:0];
   end

   // column cells: cell c holds the symbol of age c and the weights of column c
   for (genvar c = 0; c < MAX_MOTIF_LEN; c++) begin : g_cell
      logic [BASE_BITS-1:0] sym_in;
      if (c == 0) begin : g_head
         assign sym_in = req_base;
      end else begin : g_link
         assign sym_in = hist[c - 1];
      end
      pwm_cell #(
         .COL         (c),
         .WEIGHT_BITS (WEIGHT_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .load_weight (weight_sat),
         .sym_in      (sym_in),
         .sym_out     (hist[c]),
         .aligned_sym (aligned[c]),
         .contrib     (contrib[c])
      );
   end

   // line the oldest symbol of the window up with column 0: the history,
   // reversed, shifted down by MAX_MOTIF_LEN - length, other fills the top
   assign sh = SHB'(MAX_MOTIF_LEN - int'(len_ff));

   always_comb begin
      logic [BASE_BITS-1:0] shf [0:SHB][MAX_MOTIF_LEN];
      for (int i = 0; i < MAX_MOTIF_LEN; i++) begin
         shf[0][i] = hist[MAX_MOTIF_LEN - 1 - i];
      end
      for (int s = 0; s < SHB; s++) begin
         for (int i = 0; i < MAX_MOTIF_LEN; i++) begin
            if (!sh[s]) begin
               shf[s + 1][i] = shf[s][i];
            end else if (i + (1 << s) < MAX_MOTIF_LEN) begin
               shf[s + 1][i] = shf[s][i + (1 << s)];
            end else begin
               shf[s + 1][i] = SYM_OTHER;
            end
         end
      end
      for (int i = 0; i < MAX_MOTIF_LEN; i++) begin
         aligned[i] = shf[SHB][i];
      end
   end

   pwm_sum_tree #(
      .N        (MAX_MOTIF_LEN),
      .IN_BITS  (WEIGHT_BITS),
      .SUM_BITS (SUM_BITS),
      .TAG_BITS (TAG_BITS)
   ) u_tree (
      .clock   (clock),
      .reset   (reset),
      .leaf    (contrib),
      .tag_in  (s1_tag_ff),
      .sum     (root),
      .tag_out (root_tag_bits)
   );

   assign root_tag = tag_type'(root_tag_bits);

   // saturate the window score and compare with the threshold
   always_comb begin
      root_ext = EXT_BITS'(root);
      if (root_ext > EXT_BITS'(SCORE_MAX)) begin
         score_sat = SCORE_MAX;
      end else if (root_ext < EXT_BITS'(SCORE_MIN)) begin
         score_sat = SCORE_MIN;
      end else begin
         score_sat = SCORE_BITS'(root_ext);
      end
      hit  = root_tag.valid && (score_sat > thresh_ff);
      drop = root_tag.valid && !hit;
      push_word.score = score_sat;
      push_word.start = root_tag.start;
      push_word.seq   = root_tag.seq;
   end

   pwm_fifo #(
      .WIDTH ($bits(rsp_word_type)),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (hit),
      .wdata     (push_word),
      .pop       (pop),
      .rdata     (fifo_rdata),
      .not_empty (rsp_tvalid)
   );

   assign pop      = rsp_tvalid && rsp_tready;
   assign out_word = rsp_word_type'(fifo_rdata);

   // result slots: reserved by a full-window scan, freed on drop or read-out
   always_comb begin
      credit_in = credit_ff;
      if (reserve) begin
         credit_in = credit_in + 1'b1;
      end
      if (drop) begin
         credit_in = credit_in - 1'b1;
      end
      if (pop) begin
         credit_in = credit_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   assign req_tready = (credit_ff != CREDIT_BITS'(FIFO_DEPTH));
   assign rsp_tdata  = RSP_DATA_BITS'(out_word);

endmodule

### sim/tb_pwm_motif_scan.sv
`timescale 1ns / 100ps

module tb_pwm_motif_scan;
   import pwm_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [2:0] BASE_A = 3'd0;
   localparam logic [2:0] BASE_T = 3'd1;
   localparam logic [2:0] BASE_G = 3'd2;
   localparam logic [2:0] BASE_C = 3'd3;
   localparam int MAX_LEN    = 32;
   localparam int LAT_WAIT   = 20;    // margin for a scan word to reach the result queue
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic [SEQ_BITS-1:0]          seq;
      logic [START_BITS-1:0]        start;
      logic signed [SCORE_BITS-1:0] score;
   } hit_type;

   typedef struct {
      logic [1:0]  cmd;
      logic [2:0]  base;
      logic [4:0]  column;
      logic [15:0] weight;
      bit          typed;
      hit_type     hit;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // base, column, weight
   logic [REQ_USER_BITS-1:0] req_tuser = '0;   // cmd
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // sequence_index, start_position, score
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // hand-typed result travelling alongside the request word
   bit      req_typed = 1'b0;
   hit_type req_typed_hit = '0;

   bit quiet = 1'b0;
   int errors = 0;
   int idle_cycles = 0;
   int n_loads = 0, n_scans = 0, n_newseq = 0, n_other = 0, n_hits = 0, n_settings = 0;
   int stall_left = 0;

   // predictor state
   logic signed [15:0] wt [NUM_BASES][MAX_LEN];
   logic [2:0]  win [MAX_LEN];
   logic [15:0] seen;
   logic [7:0]  seqno;
   logic [5:0]  mlen;
   logic signed [20:0] thr;

   hit_type pending_hits [$];
   dir_row_type dir_tab [$];

   pwm_motif_scan DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // window score of one accepted word, updates the predictor state
   task automatic track_word(input logic [1:0] cmd, input logic [2:0] base,
                             input logic [4:0] column, input logic [15:0] weight,
                             output bit found, output hit_type hit);
      int len;
      int sum;
      logic [2:0] b;
      found = 1'b0;
      hit = '0;
      case (cmd)
         CMD_LOAD: begin
            n_loads++;
            if (base < SYM_OTHER) wt[base[1:0]][column] = weight;
         end
         CMD_NEWSEQ: begin
            n_newseq++;
            for (int i = 0; i < MAX_LEN; i++) win[i] = SYM_OTHER;
            seen = '0;
            seqno = seqno + 8'd1;
         end
         CMD_SCAN: begin
            n_scans++;
            for (int i = MAX_LEN - 1; i > 0; i--) win[i] = win[i-1];
            win[0] = base;
            if (seen != 16'hFFFF) seen = seen + 16'd1;
            len = (mlen == 0) ? 1 : ((mlen > MAX_LEN) ? MAX_LEN : int'(mlen));
            if (int'(seen) >= len) begin
               sum = 0;
               for (int k = 0; k < len; k++) begin
                  b = win[len-1-k];
                  if (b < SYM_OTHER) sum += int'(wt[b[1:0]][k]);
               end
               if (sum > int'(SCORE_MAX)) sum = int'(SCORE_MAX);
               if (sum < int'(SCORE_MIN)) sum = int'(SCORE_MIN);
               if (sum > int'(thr)) begin
                  found = 1'b1;
                  hit.seq = seqno;
                  hit.start = seen - 16'(len) + 16'd1;
                  hit.score = 21'(sum);
               end
            end
         end
         default: n_other++;
      endcase
   endtask

   // one field of a result against the oldest expectation
   task automatic check_field(input string label, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
      end
   endtask

   // monitor: registers, results, accepted words and the watchdog
   always @(posedge clock) begin : monitor
      bit found;
      hit_type h;
      hit_type want;
      if (!reset) begin
         if (csr_wr_en) begin
            if (csr_index == CSR_MOTIF_LENGTH) mlen = csr_wdata[5:0];
            else thr = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_hits.size() == 0) begin
               errors++;
               $display("%0t: unexpected result word, expected none actual %h",
                        $time, rsp_tdata);
            end else begin
               want = pending_hits.pop_front();
               n_hits++;
               check_field("sequence_index", want.seq, rsp_tdata[7:0]);
               check_field("start_position", want.start, rsp_tdata[23:8]);
               check_field("score", want.score, $signed(rsp_tdata[44:24]));
            end
         end
         if (req_tvalid && req_tready) begin
            track_word(req_tuser, req_tdata[2:0], req_tdata[7:3], req_tdata[23:8], found, h);
            if (req_typed) pending_hits.push_back(req_typed_hit);
            else if (found) pending_hits.push_back(h);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (quiet) begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic hit_type mk_hit(input int seq, input int start, input int score);
      hit_type h;
      h.seq = 8'(seq);
      h.start = 16'(start);
      h.score = 21'(score);
      return h;
   endfunction

   function automatic dir_row_type row(input logic [1:0] cmd, input logic [2:0] base,
                                       input int column, input int weight,
                                       input bit typed, input hit_type hit);
      dir_row_type r;
      r.cmd = cmd;
      r.base = base;
      r.column = 5'(column);
      r.weight = 16'(weight);
      r.typed = typed;
      r.hit = hit;
      return r;
   endfunction

   function automatic logic [15:0] rand_weight();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // drive one word and hold it until accepted
   task automatic push_word(input logic [1:0] cmd, input logic [2:0] base,
                            input logic [4:0] column, input logic [15:0] weight,
                            input bit typed, input hit_type hit);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {weight, column, base};
      req_typed <= typed;
      req_typed_hit <= hit;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic push_plain(input logic [1:0] cmd, input logic [2:0] base);
      push_word(cmd, base, 5'($urandom), 16'($urandom), 1'b0, '0);
   endtask

   // sender holds off until every expected result has come, then the tree drains
   task automatic drain();
      req_tvalid <= 1'b0;
      req_typed <= 1'b0;
      @(posedge clock);
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (LAT_WAIT) @(posedge clock);
   endtask

   // both registers, written only while idle
   task automatic set_regs(input logic [5:0] len, input int threshold);
      logic [CSR_DATA_BITS-1:0] lw;
      drain();
      lw = 21'($urandom);
      lw[5:0] = len;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MOTIF_LENGTH;
      csr_wdata <= lw;
      @(posedge clock);
      csr_index <= CSR_SCORE_THRESHOLD;
      csr_wdata <= 21'(threshold);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   // mostly whole sequences with random content, some loads and noise
   task automatic run_phase(input int n_items, input int act_len);
      int sent;
      int run;
      logic [2:0] b;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(0, 19))
            0, 1: begin
               push_word(CMD_LOAD, 3'($urandom), 5'($urandom), rand_weight(), 1'b0, '0);
               sent++;
            end
            2: begin
               push_plain(CMD_UNUSED, 3'($urandom));
               sent++;
            end
            default: begin
               push_plain(CMD_NEWSEQ, 3'($urandom));
               run = $urandom_range(0, act_len + 24);
               for (int i = 0; i < run; i++) begin
                  if ($urandom_range(0, 39) == 0) begin
                     push_word(CMD_LOAD, 3'($urandom), 5'($urandom), rand_weight(),
                               1'b0, '0);
                  end else begin
                     b = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 3))
                                                    : 3'($urandom_range(4, 7));
                     push_plain(CMD_SCAN, b);
                  end
               end
               sent += run + 1;
            end
         endcase
      end
   endtask

   initial begin
      int len;
      // predictor reset state
      for (int i = 0; i < MAX_LEN; i++) win[i] = SYM_OTHER;
      for (int bs = 0; bs < NUM_BASES; bs++)
         for (int c = 0; c < MAX_LEN; c++) wt[bs][c] = '0;
      seen = '0;
      seqno = '0;
      mlen = 6'(LEN_RESET);
      thr = THRESH_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // every weight written before any scan can read it
      for (int bs = 0; bs < NUM_BASES; bs++)
         for (int c = 0; c < MAX_LEN; c++)
            push_word(CMD_LOAD, 3'(bs), 5'(c), 16'd0, 1'b0, '0);

      // directed words at the reset settings: length 16, threshold -1.78
      dir_tab.push_back(row(CMD_LOAD, BASE_A, 0, 32767, 1'b0, '0));
      dir_tab.push_back(row(CMD_LOAD, BASE_C, 15, -32768, 1'b0, '0));
      // loads of other symbols must not alias onto a, c
      dir_tab.push_back(row(CMD_LOAD, SYM_OTHER, 0, -32768, 1'b0, '0));
      dir_tab.push_back(row(CMD_LOAD, 3'd7, 15, 32767, 1'b0, '0));
      dir_tab.push_back(row(CMD_UNUSED, 3'd7, 31, -1, 1'b0, '0));
      dir_tab.push_back(row(CMD_SCAN, BASE_A, 31, 0, 1'b0, '0));
      for (int i = 0; i < 14; i++)
         dir_tab.push_back(row(CMD_SCAN, 3'(4 + i % 4), i, i, 1'b0, '0));
      // first full window: a in column 0 plus c in column 15
      dir_tab.push_back(row(CMD_SCAN, BASE_C, 0, 0, 1'b1, mk_hit(0, 1, -1)));
      dir_tab.push_back(row(CMD_SCAN, BASE_G, 0, 0, 1'b1, mk_hit(0, 2, 0)));
      dir_tab.push_back(row(CMD_NEWSEQ, BASE_A, 0, 0, 1'b0, '0));
      dir_tab.push_back(row(CMD_SCAN, BASE_T, 7, 100, 1'b0, '0));
      foreach (dir_tab[i])
         push_word(dir_tab[i].cmd, dir_tab[i].base, dir_tab[i].column, dir_tab[i].weight,
                   dir_tab[i].typed, dir_tab[i].hit);

      // sequence counter wraps past 255
      for (int i = 0; i < 256; i++) push_plain(CMD_NEWSEQ, 3'($urandom));

      // fresh random matrix
      for (int bs = 0; bs < NUM_BASES; bs++)
         for (int c = 0; c < MAX_LEN; c++)
            push_word(CMD_LOAD, 3'(bs), 5'(c), rand_weight(), 1'b0, '0);

      set_regs(6'd4, $urandom_range(0, 40000) - 20000);
      run_phase(150, 4);
      set_regs(6'd1, 0);
      run_phase(150, 1);
      // lowest threshold: nearly every window hits and the result queue fills
      set_regs(6'd32, int'(SCORE_MIN));
      run_phase(120, 32);
      // zero acts as one
      set_regs(6'd0, $urandom_range(0, 40000) - 20000);
      run_phase(150, 1);
      // above the maximum acts as 32
      set_regs(6'd45, $urandom_range(0, 120000) - 60000);
      run_phase(150, 32);
      // highest threshold: nothing can hit
      set_regs(6'd8, int'(SCORE_MAX));
      run_phase(100, 8);

      // last part runs without idling on either side
      len = $urandom_range(1, 32);
      set_regs(6'(len), $urandom_range(0, 80000) - 40000);
      quiet = 1'b1;
      run_phase(150, len);

      drain();
      $display("covered %0d loads, %0d scans, %0d new sequences, %0d unused words",
               n_loads, n_scans, n_newseq, n_other);
      $display("%0d results compared over %0d register settings, %0d mismatches",
               n_hits, n_settings, errors);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### pwm_motif_scan.f
src/pwm_pkg.sv
src/pwm_cell.sv
src/pwm_sum_tree.sv
src/pwm_fifo.sv
src/pwm_motif_scan.sv
sim/tb_pwm_motif_scan.sv
